// ===== hw/rtl/ccht_pkg.sv =====
// ----------------------------------------------------------------------------
// ccht_pkg
// Shared types and constants for the context count hash table core.
// ----------------------------------------------------------------------------
package ccht_pkg;

	localparam int KEY_W  = 64;
	localparam int CNT_W  = 32;
	localparam int TOK_W  = 16;
	localparam int BEST_W = 16;
	localparam int CONF_W = 17;

	// Confidence of exactly one in unsigned Q1.16.
	localparam logic [CONF_W-1:0] CONF_ONE = 17'h10000;

	// Multiplier of the home slot hash and the reserved empty key.
	localparam logic [KEY_W-1:0] MIX_MUL = 64'h9e3779b97f4a7c15;
	localparam logic [KEY_W-1:0] NO_KEY  = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [CNT_W-1:0]  CNT_MAX  = 32'hFFFF_FFFF;
	localparam logic [BEST_W-1:0] BEST_MAX = 16'hFFFF;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  count;
		logic [TOK_W-1:0]  top_tok;
		logic [BEST_W-1:0] best_cnt;
	} ctx_entry_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} pair_entry_t;

	localparam ctx_entry_t  CTX_EMPTY  = '{key: NO_KEY, count: '0, top_tok: '0, best_cnt: '0};
	localparam pair_entry_t PAIR_EMPTY = '{key: NO_KEY, count: '0};

	function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
		sat_inc32 = (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

endpackage

// ===== hw/rtl/context_count_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// context_count_hash_table_core
// Context and pair count tables, open addressed with linear probing.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata                                    tuser
// s_axis    in   context_key, pr_key, token (144 bits)    func
// m_axis    out  best_token, confidence, total_count      found
//
// After reset both tables are swept to empty, one slot a cycle, and
// s_axis_tready stays low until the sweep is done.
// One item is worked at a time. A lookup probes the context table, at most
// PROBE_LIMIT slots; on a hit the divider works out the confidence, and a
// ratio of one or more needs no division. A lookup that misses goes
// straight to the result. An update probes the pair table and then the
// context table. Each probe passes through a read state and a compare state
// because the table read data is registered.
// A waiting result sits in the output register; a further lookup stalls
// only when it finishes while the previous result is still untaken.
//
module context_count_hash_table_core
	import ccht_pkg::*;
#(
	parameter int TABLE_BITS  = 10,
	parameter int PROBE_LIMIT = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // context_key[63:0], pr_key[127:64], token[143:128]
	input  logic [0:0]   s_axis_tuser,  // func[0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,  // best_token[15:0], confidence[32:16],
	                                    // total_count[64:33], zero fill[71:65]
	output logic [0:0]   m_axis_tuser   // found[0]
);

	localparam int SLOTS   = 1 << TABLE_BITS;
	localparam int PROBE_W = $clog2(PROBE_LIMIT + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_CMP   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_RES   = 3'd6;

	localparam logic FUNC_LOOKUP = 1'b0;

	// Control state.
	logic [2:0]            state_q;
	logic [TABLE_BITS-1:0] clr_q;
	logic [TABLE_BITS-1:0] slot_q;
	logic [PROBE_W-1:0]    probe_q;
	logic                  func_q;
	logic                  phase_q;   // 0 pair table, 1 context table
	logic                  found_q;
	logic                  out_valid_q;

	// Item payload.
	logic [KEY_W-1:0] ctx_key_q;
	logic [KEY_W-1:0] pr_key_q;
	logic [TOK_W-1:0] tok_q;
	logic [CNT_W-1:0] pcount_q;
	logic [TOK_W-1:0] hit_tok_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [71:0]      out_data_q;
	logic             out_user_q;

	// Tables and their registered read data.
	ctx_entry_t  ctx_mem  [SLOTS];
	pair_entry_t pair_mem [SLOTS];
	ctx_entry_t  ctx_rd_q;
	pair_entry_t pair_rd_q;

	logic                  ctx_we, pair_we;
	logic [TABLE_BITS-1:0] wr_addr;
	ctx_entry_t            ctx_wd;
	pair_entry_t           pair_wd;

	// Home slot: only the low bits of the product matter, and those depend on
	// the low bits of the key alone.
	logic [KEY_W-1:0]        hash_key;
	logic [2*TABLE_BITS-1:0] hash_prod;

	assign hash_key  = phase_q ? ctx_key_q : pr_key_q;
	assign hash_prod = hash_key[TABLE_BITS-1:0] * MIX_MUL[TABLE_BITS-1:0];

	// Probe decisions on the entry just read.
	logic cur_match, cur_empty, last_probe;
	assign cur_match  = phase_q ? (ctx_rd_q.key == ctx_key_q) : (pair_rd_q.key == pr_key_q);
	assign cur_empty  = phase_q ? (ctx_rd_q.key == NO_KEY) : (pair_rd_q.key == NO_KEY);
	assign last_probe = (probe_q == PROBE_W'(PROBE_LIMIT - 1));

	// Context entry after an update hit.
	ctx_entry_t ctx_bumped;
	always_comb begin
		ctx_bumped       = ctx_rd_q;
		ctx_bumped.count = sat_inc32(ctx_rd_q.count);
		if (tok_q == ctx_rd_q.top_tok) begin
			if (ctx_rd_q.best_cnt != BEST_MAX) begin
				ctx_bumped.best_cnt = ctx_rd_q.best_cnt + 16'd1;
			end
		end else if (pcount_q > {16'd0, ctx_rd_q.best_cnt}) begin
			ctx_bumped.top_tok  = tok_q;
			ctx_bumped.best_cnt = (pcount_q[CNT_W-1:BEST_W] != '0) ? BEST_MAX
			                                                      : pcount_q[BEST_W-1:0];
		end
	end

	logic [CNT_W-1:0] pair_new_cnt;
	assign pair_new_cnt = cur_empty ? 32'd1 : sat_inc32(pair_rd_q.count);

	// Table write port: the clearing sweep or the entry under the probe.
	always_comb begin
		ctx_we  = 1'b0;
		pair_we = 1'b0;
		wr_addr = slot_q;
		ctx_wd  = CTX_EMPTY;
		pair_wd = PAIR_EMPTY;
		if (state_q == ST_CLEAR) begin
			ctx_we  = 1'b1;
			pair_we = 1'b1;
			wr_addr = clr_q;
		end else if (state_q == ST_CMP && func_q != FUNC_LOOKUP && (cur_match || cur_empty)) begin
			if (phase_q) begin
				ctx_we = 1'b1;
				if (cur_match) begin
					ctx_wd = ctx_bumped;
				end else begin
					ctx_wd = '{key: ctx_key_q, count: 32'd1, top_tok: tok_q, best_cnt: 16'd1};
				end
			end else begin
				pair_we = 1'b1;
				pair_wd = '{key: pr_key_q, count: pair_new_cnt};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctx_we) begin
			ctx_mem[wr_addr] <= ctx_wd;
		end
		ctx_rd_q <= ctx_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (pair_we) begin
			pair_mem[wr_addr] <= pair_wd;
		end
		pair_rd_q <= pair_mem[slot_q];
	end

	// Confidence divider.
	logic              div_start;
	logic              div_busy;
	logic [CONF_W-1:0] div_quot;

	assign div_start = (state_q == ST_CMP) && phase_q && (func_q == FUNC_LOOKUP) && cur_match;

	ccht_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ctx_rd_q.best_cnt),
		.divisor  (ctx_rd_q.count),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	logic s_accept, res_load;
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign res_load = (state_q == ST_RES) && (!out_valid_q || m_axis_tready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			slot_q  <= '0;
			probe_q <= '0;
			func_q  <= FUNC_LOOKUP;
			phase_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						func_q  <= s_axis_tuser[0];
						// A lookup goes straight to the context table.
						phase_q <= (s_axis_tuser[0] == FUNC_LOOKUP);
						found_q <= 1'b0;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_key == NO_KEY) begin
						// The reserved key never matches: skip this table.
						if (!phase_q) begin
							phase_q <= 1'b1;
						end else if (func_q == FUNC_LOOKUP) begin
							state_q <= ST_RES;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						slot_q  <= hash_prod[TABLE_BITS-1:0];
						probe_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cur_match || cur_empty || last_probe) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= ST_HASH;
						end else if (func_q == FUNC_LOOKUP) begin
							found_q <= cur_match;
							state_q <= cur_match ? ST_DIV : ST_RES;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						slot_q  <= slot_q + 1'b1;
						probe_q <= probe_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload and the pair count handed to the context update.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			ctx_key_q <= s_axis_tdata[63:0];
			pr_key_q  <= s_axis_tdata[127:64];
			tok_q     <= s_axis_tdata[143:128];
			pcount_q  <= '0;
		end
		if (state_q == ST_CMP && !phase_q) begin
			if (cur_match || cur_empty) begin
				pcount_q <= pair_new_cnt;
			end else if (last_probe) begin
				pcount_q <= '0;
			end
		end
		if (div_start) begin
			hit_tok_q <= ctx_rd_q.top_tok;
			hit_cnt_q <= ctx_rd_q.count;
		end
	end

	// Output register: frees the sequencer while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_user_q <= found_q;
			if (found_q) begin
				out_data_q <= {7'd0, hit_cnt_q, div_quot, hit_tok_q};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Checks.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		probe_q < PROBE_W'(PROBE_LIMIT))
		else $error("probe counter passed the probe limit");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV))
		else $error("divider busy outside the divide state");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("miss result carries non-zero data");

	a_conf_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[32:16] <= CONF_ONE))
		else $error("confidence above one");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_DIV))
		else $error("divider started without entering the divide state");

endmodule

// ===== hw/rtl/ccht_div.sv =====
// ----------------------------------------------------------------------------
// ccht_div
// Restoring divider for the confidence ratio, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccht_div
	import ccht_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [BEST_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              busy,
	output logic [CONF_W-1:0] quot
);

	localparam int STEP_W = $clog2(BEST_W);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [CONF_W-1:0] quot_q;
	logic [CNT_W+1:0]  trial;

	// The shared subtractor: shifted remainder minus divisor.
	assign trial = {1'b0, rem_q, 1'b0} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			step_q <= '0;
			// A ratio of one or more saturates, and a zero divisor gives zero.
			busy_q <= (divisor != '0) && ({16'd0, dividend} < divisor);
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(BEST_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {16'd0, dividend};
			div_q <= divisor;
			if (divisor == '0) begin
				quot_q <= '0;
			end else if ({16'd0, dividend} >= divisor) begin
				quot_q <= CONF_ONE;
			end else begin
				quot_q <= '0;
			end
		end else if (busy_q) begin
			if (!trial[CNT_W+1]) begin
				rem_q  <= trial[CNT_W-1:0];
				quot_q <= {quot_q[CONF_W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[CNT_W-2:0], 1'b0};
				quot_q <= {quot_q[CONF_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule
